// ----- src/sacdb_pkg.sv -----
`timescale 1ns / 1ps

package sacdb_pkg;

    // register file
    localparam int NUM_REGS  = 64;
    localparam int REG_IDX_W = 6;
    localparam int REG_AW    = $clog2(NUM_REGS);

    // configuration port
    localparam int CFG_AW    = 3;
    localparam int CFG_IDX_W = CFG_AW - 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BRANCH_BASE = '0;

    // opcodes
    localparam logic [4:0] OP_NOP    = 5'd0;
    localparam logic [4:0] OP_ADD    = 5'd1;
    localparam logic [4:0] OP_SUB    = 5'd2;
    localparam logic [4:0] OP_XOR    = 5'd3;
    localparam logic [4:0] OP_OR     = 5'd4;
    localparam logic [4:0] OP_AND    = 5'd5;
    localparam logic [4:0] OP_LSL    = 5'd6;
    localparam logic [4:0] OP_LSR    = 5'd7;
    localparam logic [4:0] OP_ASR    = 5'd8;
    localparam logic [4:0] OP_MOV    = 5'd9;
    localparam logic [4:0] OP_MOVZ   = 5'd10;
    localparam logic [4:0] OP_CMP    = 5'd11;
    localparam logic [4:0] OP_END    = 5'd12;
    localparam logic [4:0] OP_BNE    = 5'd13;
    localparam logic [4:0] OP_BEQ    = 5'd14;
    localparam logic [4:0] OP_BL     = 5'd15;
    localparam logic [4:0] OP_BLE    = 5'd16;
    localparam logic [4:0] OP_BG     = 5'd17;
    localparam logic [4:0] OP_BGE    = 5'd18;
    localparam logic [4:0] OP_BLS    = 5'd19;
    localparam logic [4:0] OP_BLES   = 5'd20;
    localparam logic [4:0] OP_BGS    = 5'd21;
    localparam logic [4:0] OP_BGES   = 5'd22;
    localparam logic [4:0] OP_BRA    = 5'd23;
    localparam logic [4:0] OP_JMP    = 5'd24;
    localparam logic [4:0] OP_CALL   = 5'd25;
    localparam logic [4:0] OP_JMPBR  = 5'd26;
    localparam logic [4:0] OP_CALLBR = 5'd27;
    localparam logic [4:0] OP_RET    = 5'd28;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ILLEGAL = 2'd1;
    localparam logic [1:0] ST_END     = 2'd2;

    // flag bit positions
    localparam int FLAG_NE = 0;
    localparam int FLAG_SL = 1;
    localparam int FLAG_UL = 2;

    typedef struct packed {
        logic [4:0]           op;
        logic [REG_IDX_W-1:0] dest_reg;
        logic [REG_IDX_W-1:0] src_b_reg;
        logic [REG_IDX_W-1:0] src_c_reg;
        logic                 use_immediate;
        logic signed [31:0]   immediate;
    } instr_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        program_counter;
        logic signed [31:0] result_value;
        logic [2:0]         flag_bits;
    } res_t;

endpackage

// ----- src/scalar_alu_compare_delayed_branch.sv -----
`timescale 1ns / 1ps

// operands are read into registers when an instruction is taken, then its result is registered after execute
// throughput: one instruction per cycle while res_stall does not hold the output, set by the single execute stage
// register file reads are registered with write-to-read forwarding from the execute stage
// reset clears flags, pc, link register, pending branch, branch base and all register
// valid bits, so every register reads as zero; no clearing pass is needed
module scalar_alu_compare_delayed_branch (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sacdb_pkg::CFG_AW-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                instr_valid,
    output logic                                instr_stall,
    input  sacdb_pkg::instr_t                   instr,
    output logic                                res_valid,
    input  logic                                res_stall,
    output sacdb_pkg::res_t                     res
);

    localparam int IDX_W = sacdb_pkg::REG_IDX_W;
    localparam int AW    = sacdb_pkg::REG_AW;
    localparam logic [IDX_W:0] REG_LIMIT = (IDX_W + 1)'(sacdb_pkg::NUM_REGS);

    function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
        return {1'b0, idx} < REG_LIMIT;
    endfunction

    // configuration
    logic [31:0]                      branch_base_reg;
    logic                             cfg_wr;
    logic [sacdb_pkg::CFG_IDX_W-1:0]  cfg_idx;

    // register file
    logic [31:0]                 rf_mem [sacdb_pkg::NUM_REGS];
    logic [sacdb_pkg::NUM_REGS-1:0] rf_vld_reg;

    // architectural state
    logic [2:0]  flags_reg, flags_next;
    logic [31:0] pc_reg, pc_next;
    logic [31:0] lr_reg, lr_next;
    logic        pend_reg, pend_next;
    logic [4:0]  pend_kind_reg, pend_kind_next;
    logic [15:0] pend_off_reg, pend_off_next;

    // pipeline
    logic                s1_vld_reg;
    sacdb_pkg::instr_t   s1_instr_reg;
    logic [31:0]         opb_mem_reg, opx_mem_reg, fwd_data_reg;
    logic                opb_ok_reg, opx_ok_reg, opb_fwd_reg, opx_fwd_reg;
    logic                out_vld_reg;
    sacdb_pkg::res_t     res_reg, res_next;

    logic                accept, advance;
    logic [IDX_W-1:0]    rx_idx;
    logic                wr_en, wr_req;
    logic [31:0]         wr_data;

    logic [31:0] opb, opx, opc, alu;
    logic [4:0]  sh;
    logic [31:0] tgt;
    logic        ne, sl, ul, take, run;
    logic [1:0]  status;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[sacdb_pkg::CFG_AW-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (cfg_idx == sacdb_pkg::CFG_IDX_BRANCH_BASE) ? branch_base_reg : 32'd0;

    // handshake
    assign advance     = s1_vld_reg && (!out_vld_reg || !res_stall);
    assign instr_stall = s1_vld_reg && !advance;
    assign accept      = instr_valid && !instr_stall;
    assign res_valid   = out_vld_reg;
    assign res         = res_reg;

    // compare reads dest_reg on the second port
    assign rx_idx = (instr.op == sacdb_pkg::OP_CMP) ? instr.dest_reg : instr.src_c_reg;

    assign wr_en   = advance && wr_req;
    assign wr_data = alu;

    // operands, with forwarding from the instruction that retired as this one came in
    assign opb = opb_fwd_reg ? fwd_data_reg : (opb_ok_reg ? opb_mem_reg : 32'd0);
    assign opx = opx_fwd_reg ? fwd_data_reg : (opx_ok_reg ? opx_mem_reg : 32'd0);
    assign opc = s1_instr_reg.use_immediate ? s1_instr_reg.immediate : opx;
    assign sh  = opc[4:0];

    always_comb
    begin
        case (s1_instr_reg.op)
            sacdb_pkg::OP_ADD: alu = opb + opc;
            sacdb_pkg::OP_SUB: alu = opb - opc;
            sacdb_pkg::OP_XOR: alu = opb ^ opc;
            sacdb_pkg::OP_OR:  alu = opb | opc;
            sacdb_pkg::OP_AND: alu = opb & opc;
            sacdb_pkg::OP_LSL: alu = opb << sh;
            sacdb_pkg::OP_LSR: alu = opb >> sh;
            sacdb_pkg::OP_ASR: alu = 32'($signed(opb) >>> sh);
            sacdb_pkg::OP_MOV: alu = opb;
            default:           alu = 32'd0;
        endcase
    end

    assign ne  = flags_reg[sacdb_pkg::FLAG_NE];
    assign sl  = flags_reg[sacdb_pkg::FLAG_SL];
    assign ul  = flags_reg[sacdb_pkg::FLAG_UL];
    assign tgt = {16'd0, pend_off_reg};

    always_comb
    begin
        flags_next     = flags_reg;
        pc_next        = pc_reg;
        lr_next        = lr_reg;
        pend_next      = pend_reg;
        pend_kind_next = pend_kind_reg;
        pend_off_next  = pend_off_reg;
        status         = sacdb_pkg::ST_OK;
        wr_req         = 1'b0;
        take           = 1'b0;
        run            = 1'b1;

        // the pending branch resolves before the new instruction
        if (pend_reg)
        begin
            case (pend_kind_reg)
                sacdb_pkg::OP_BNE:    take = ne;
                sacdb_pkg::OP_BEQ:    take = !ne;
                sacdb_pkg::OP_BL:     take = ul;
                sacdb_pkg::OP_BLE:    take = ul || !ne;
                sacdb_pkg::OP_BG:     take = !ul;
                sacdb_pkg::OP_BGE:    take = !ul || !ne;
                sacdb_pkg::OP_BLS:    take = sl;
                sacdb_pkg::OP_BLES:   take = sl || !ne;
                sacdb_pkg::OP_BGS:    take = !sl;
                sacdb_pkg::OP_BGES:   take = !sl || !ne;
                sacdb_pkg::OP_BRA:    take = 1'b1;
                sacdb_pkg::OP_JMP:    pc_next = tgt;
                sacdb_pkg::OP_CALL:
                begin
                    lr_next = pc_reg;
                    pc_next = tgt;
                end
                sacdb_pkg::OP_JMPBR:  pc_next = branch_base_reg + tgt;
                sacdb_pkg::OP_CALLBR:
                begin
                    lr_next = pc_reg;
                    pc_next = branch_base_reg + tgt;
                end
                sacdb_pkg::OP_RET:    pc_next = lr_reg;
                default:              run = 1'b0;
            endcase
            if (take)
            begin
                pc_next = pc_reg + tgt;
            end
            if (run)
            begin
                pend_next = 1'b0;
            end
            else
            begin
                status = sacdb_pkg::ST_ILLEGAL;
            end
        end

        if (run)
        begin
            case (s1_instr_reg.op) inside
                sacdb_pkg::OP_NOP: ;
                [sacdb_pkg::OP_ADD:sacdb_pkg::OP_MOVZ]:
                    wr_req = idx_in_range(s1_instr_reg.dest_reg);
                sacdb_pkg::OP_CMP:
                begin
                    flags_next[sacdb_pkg::FLAG_NE] = opb != opx;
                    flags_next[sacdb_pkg::FLAG_SL] = $signed(opb) < $signed(opx);
                    flags_next[sacdb_pkg::FLAG_UL] = opb < opx;
                end
                sacdb_pkg::OP_END: status = sacdb_pkg::ST_END;
                [sacdb_pkg::OP_BNE:sacdb_pkg::OP_RET]:
                begin
                    pend_next      = 1'b1;
                    pend_kind_next = s1_instr_reg.op;
                    pend_off_next  = s1_instr_reg.immediate[15:0];
                end
                default: status = sacdb_pkg::ST_ILLEGAL;
            endcase
        end

        res_next.status          = status;
        res_next.program_counter = pc_next;
        res_next.result_value    = (run && s1_instr_reg.op inside
                                    {[sacdb_pkg::OP_ADD:sacdb_pkg::OP_MOVZ]}) ? alu : 32'd0;
        res_next.flag_bits       = flags_next;
    end

    // register file memory and operand read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rf_mem[s1_instr_reg.dest_reg[AW-1:0]] <= wr_data;
        end
        if (accept)
        begin
            opb_mem_reg <= rf_mem[instr.src_b_reg[AW-1:0]];
            opx_mem_reg <= rf_mem[rx_idx[AW-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_instr_reg <= instr;
            opb_ok_reg   <= idx_in_range(instr.src_b_reg)
                            && rf_vld_reg[instr.src_b_reg[AW-1:0]];
            opx_ok_reg   <= idx_in_range(rx_idx) && rf_vld_reg[rx_idx[AW-1:0]];
            opb_fwd_reg  <= wr_en && (s1_instr_reg.dest_reg == instr.src_b_reg);
            opx_fwd_reg  <= wr_en && (s1_instr_reg.dest_reg == rx_idx);
            fwd_data_reg <= wr_data;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            branch_base_reg <= 32'd0;
            rf_vld_reg      <= '0;
            flags_reg       <= 3'd0;
            pc_reg          <= 32'd0;
            lr_reg          <= 32'd0;
            pend_reg        <= 1'b0;
            pend_kind_reg   <= 5'd0;
            pend_off_reg    <= 16'd0;
            s1_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr && (cfg_idx == sacdb_pkg::CFG_IDX_BRANCH_BASE))
            begin
                branch_base_reg <= pwdata;
            end
            if (wr_en)
            begin
                rf_vld_reg[s1_instr_reg.dest_reg[AW-1:0]] <= 1'b1;
            end
            if (advance)
            begin
                flags_reg     <= flags_next;
                pc_reg        <= pc_next;
                lr_reg        <= lr_next;
                pend_reg      <= pend_next;
                pend_kind_reg <= pend_kind_next;
                pend_off_reg  <= pend_off_next;
            end
            if (accept)
            begin
                s1_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_vld_reg <= 1'b0;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

endmodule
